[rtl/core/bjl_pkg.sv]
package bjl_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int SCALE_WIDTH     = 17;
  localparam int QUOT_BITS       = 17;
  localparam logic [SCALE_WIDTH-1:0] ONE_Q16 = 17'd65536;

endpackage

[rtl/core/bjl_divider.sv]
module bjl_divider #(
  parameter int DEN_WIDTH = bjl_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  input  logic [DEN_WIDTH+bjl_pkg::SCALE_WIDTH-1:0]     in_num,
  input  logic [DEN_WIDTH-1:0]                          in_den,
  output logic                                          out_valid,
  output logic [bjl_pkg::SCALE_WIDTH-1:0]               out_quot
);

  localparam int QB = bjl_pkg::QUOT_BITS;
  localparam int NW = DEN_WIDTH + bjl_pkg::SCALE_WIDTH;

  logic [NW-1:0]        rem_r   [0:QB];
  logic [DEN_WIDTH-1:0] den_r   [0:QB];
  logic [QB-1:0]        quot_r  [0:QB];
  logic                 sat_r   [0:QB];
  logic                 valid_r [0:QB];

  // A quotient of 2^17 or more, or a zero divisor, saturates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else begin
      valid_r[0] <= in_valid;
    end
    rem_r[0]  <= in_num;
    den_r[0]  <= in_den;
    quot_r[0] <= '0;
    sat_r[0]  <= (in_num >> QB) >= NW'(in_den);
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [NW-1:0] trial;
    logic          take;
    assign trial = NW'(den_r[k]) << (QB - 1 - k);
    assign take  = rem_r[k] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k+1] <= 1'b0;
      end else begin
        valid_r[k+1] <= valid_r[k];
      end
      rem_r[k+1]  <= take ? rem_r[k] - trial : rem_r[k];
      den_r[k+1]  <= den_r[k];
      quot_r[k+1] <= quot_r[k] | (take ? (QB'(1) << (QB - 1 - k)) : '0);
      sat_r[k+1]  <= sat_r[k];
    end
  end

  assign out_valid = valid_r[QB];
  assign out_quot  = (sat_r[QB] || (quot_r[QB] > bjl_pkg::ONE_Q16)) ? bjl_pkg::ONE_Q16
                                                                      : quot_r[QB];

endmodule

[rtl/core/barth_jespersen_limiter.sv]
// Barth-Jespersen slope limiter. One cell beat enters on start in every cycle
// (busy never rises) and its limiter factor appears on out_limiter_factor with
// out_valid after the input, difference and multiply stages, the 17-step
// restoring divider per edge (one quotient bit a stage) and the output min
// register; the receiver cannot stall. Write cfg_wdata (alpha, Q1.16)
// only while no beat is in flight.
module barth_jespersen_limiter #(
  parameter int VALUE_WIDTH = bjl_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [VALUE_WIDTH-1:0]        in_left_vertex,
  input  logic signed [VALUE_WIDTH-1:0]        in_right_vertex,
  input  logic signed [VALUE_WIDTH-1:0]        in_left_average,
  input  logic signed [VALUE_WIDTH-1:0]        in_target_average,
  input  logic signed [VALUE_WIDTH-1:0]        in_right_average,
  output logic                                 out_valid,
  output logic [bjl_pkg::SCALE_WIDTH-1:0]      out_limiter_factor,
  input  logic                                 cfg_we,
  input  logic [bjl_pkg::SCALE_WIDTH-1:0]      cfg_wdata
);

  localparam int W   = VALUE_WIDTH;
  localparam int SW  = bjl_pkg::SCALE_WIDTH;
  localparam int NW  = W + SW;
  localparam int LAT = 22;

  logic [SW-1:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= bjl_pkg::ONE_Q16;
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // Stage a: capture the beat.
  logic                valid_a_r;
  logic signed [W-1:0] vl_r, vr_r, cl_r, ct_r, cr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else begin
      valid_a_r <= start;
    end
    vl_r <= in_left_vertex;
    vr_r <= in_right_vertex;
    cl_r <= in_left_average;
    ct_r <= in_target_average;
    cr_r <= in_right_average;
  end

  // Stage b: exact non-negative numerator and denominator per edge.
  function automatic logic [2*W-1:0] edge_terms(logic signed [W-1:0] v,
                                                logic signed [W-1:0] t,
                                                logic signed [W-1:0] n);
    logic signed [W:0] bound;
    logic signed [W:0] num;
    logic signed [W:0] den;
    bound = '0;
    num   = '0;
    den   = '0;
    if (v > t) begin
      bound = (n > t) ? (W+1)'(n) : (W+1)'(t);
      num   = bound - (W+1)'(t);
      den   = (W+1)'(v) - (W+1)'(t);
    end else if (v < t) begin
      bound = (n < t) ? (W+1)'(n) : (W+1)'(t);
      num   = (W+1)'(t) - bound;
      den   = (W+1)'(t) - (W+1)'(v);
    end
    return {num[W-1:0], den[W-1:0]};
  endfunction

  logic         valid_b_r;
  logic [W-1:0] num_l_r, den_l_r, num_r_r, den_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
    end else begin
      valid_b_r <= valid_a_r;
    end
    {num_l_r, den_l_r} <= edge_terms(vl_r, ct_r, cl_r);
    {num_r_r, den_r_r} <= edge_terms(vr_r, ct_r, cr_r);
  end

  // Stage c: scale the numerators.
  logic          valid_c_r;
  logic [NW-1:0] prod_l_r, prod_r_r;
  logic [W-1:0]  dl_c_r, dr_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_c_r <= 1'b0;
    end else begin
      valid_c_r <= valid_b_r;
    end
    prod_l_r <= NW'(scale_r) * NW'(num_l_r);
    prod_r_r <= NW'(scale_r) * NW'(num_r_r);
    dl_c_r   <= den_l_r;
    dr_c_r   <= den_r_r;
  end

  logic          div_valid_l, div_valid_r;
  logic [SW-1:0] phi_l, phi_r;

  bjl_divider #(.DEN_WIDTH(W)) u_div_left (
    .clk(clk), .rst_n(rst_n), .in_valid(valid_c_r), .in_num(prod_l_r),
    .in_den(dl_c_r), .out_valid(div_valid_l), .out_quot(phi_l)
  );

  bjl_divider #(.DEN_WIDTH(W)) u_div_right (
    .clk(clk), .rst_n(rst_n), .in_valid(valid_c_r), .in_num(prod_r_r),
    .in_den(dr_c_r), .out_valid(div_valid_r), .out_quot(phi_r)
  );

  logic          out_valid_r;
  logic [SW-1:0] factor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_valid_l;
    end
    factor_r <= (phi_l < phi_r) ? phi_l : phi_r;
  end

  assign out_valid          = out_valid_r;
  assign out_limiter_factor = factor_r;

  a_factor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_limiter_factor <= bjl_pkg::ONE_Q16)
    else $error("limiter factor above one");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without a matching input beat");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    div_valid_l == div_valid_r)
    else $error("edge dividers out of step");

endmodule

[verif/testbench.sv]
module testbench;

  localparam int VW = 32;
  localparam int PIPE_LATENCY = 22;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [VW-1:0] in_left_vertex = '0;
  logic signed [VW-1:0] in_right_vertex = '0;
  logic signed [VW-1:0] in_left_average = '0;
  logic signed [VW-1:0] in_target_average = '0;
  logic signed [VW-1:0] in_right_average = '0;
  logic out_valid;
  logic [bjl_pkg::SCALE_WIDTH-1:0] out_limiter_factor;
  logic cfg_we = 1'b0;
  logic [bjl_pkg::SCALE_WIDTH-1:0] cfg_wdata = '0;

  logic [bjl_pkg::SCALE_WIDTH-1:0] alpha_model;
  logic [bjl_pkg::SCALE_WIDTH-1:0] expected_factors[$];
  int error_count = 0;
  longint cycle_count = 0;

  always #4 clk = ~clk;

  barth_jespersen_limiter #(.VALUE_WIDTH(VW)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_left_vertex(in_left_vertex), .in_right_vertex(in_right_vertex),
    .in_left_average(in_left_average), .in_target_average(in_target_average),
    .in_right_average(in_right_average), .out_valid(out_valid),
    .out_limiter_factor(out_limiter_factor), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // floor(alpha * num / den), saturated at one; den > 0
  function automatic logic [bjl_pkg::SCALE_WIDTH-1:0] edge_factor(
      logic signed [VW-1:0] vtx, logic signed [VW-1:0] tgt, logic signed [VW-1:0] nbr);
    logic signed [VW:0] num, den;
    logic [VW+bjl_pkg::SCALE_WIDTH+1:0] quot;
    if (vtx == tgt) return bjl_pkg::ONE_Q16;
    if (vtx > tgt) begin
      num = (nbr > tgt) ? nbr - tgt : 0;
      den = vtx - tgt;
    end else begin
      num = (nbr < tgt) ? tgt - nbr : 0;
      den = tgt - vtx;
    end
    quot = ({1'b0, alpha_model} * $unsigned(num)) / $unsigned(den);
    return (quot > bjl_pkg::ONE_Q16) ? bjl_pkg::ONE_Q16 : quot[bjl_pkg::SCALE_WIDTH-1:0];
  endfunction

  // start stays high after the beat; idle_gap and drain drop it
  task automatic send_cell(logic signed [VW-1:0] lv, logic signed [VW-1:0] rv,
                           logic signed [VW-1:0] la, logic signed [VW-1:0] ta,
                           logic signed [VW-1:0] ra);
    logic [bjl_pkg::SCALE_WIDTH-1:0] pl, pr;
    in_left_vertex <= lv;
    in_right_vertex <= rv;
    in_left_average <= la;
    in_target_average <= ta;
    in_right_average <= ra;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pl = edge_factor(lv, ta, la);
    pr = edge_factor(rv, ta, ra);
    expected_factors.push_back(pl < pr ? pl : pr);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_factors.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_alpha(logic [bjl_pkg::SCALE_WIDTH-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    alpha_model = value;
  endtask

  function automatic logic signed [VW-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(VW-1){1'b0}}};
      1: return {1'b0, {(VW-1){1'b1}}};
      2: return $urandom_range(0, 200) - 100;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed_cases();
    logic signed [VW-1:0] vmin, vmax;
    vmin = {1'b1, {(VW-1){1'b0}}};
    vmax = {1'b0, {(VW-1){1'b1}}};
    send_cell(5, 5, 0, 5, 9);
    send_cell(vmax, vmin, vmin, 0, vmax);
    send_cell(vmin, vmax, vmax, 0, vmin);
    send_cell(vmax, vmin, vmin, vmax, vmin);
    send_cell(vmin, vmax, vmax, vmin, vmax);
    send_cell(10, -10, 10, 0, -10);
    send_cell(20, -30, 7, 0, -3);
    send_cell(20, -30, 0, 0, 0);
    send_cell(1, -1, vmax, 0, vmin);
    send_cell(-1, 1, -1, 0, 1);
    send_cell(3, 7, 100, 5, -100);
    send_cell(-1, -1, -1, -1, -1);
  endtask

  task automatic test_alpha_settings();
    logic [bjl_pkg::SCALE_WIDTH-1:0] alphas[4];
    alphas = '{17'd0, 17'h1FFFF, 17'd32768, 17'd1};
    foreach (alphas[k]) begin
      write_alpha(alphas[k]);
      test_directed_cases();
      for (int i = 0; i < 30; i++) begin
        send_cell(rand_value(), rand_value(), rand_value(), rand_value(), rand_value());
        idle_gap();
      end
    end
    write_alpha(bjl_pkg::ONE_Q16);
  endtask

  // mostly smooth neighborhoods, so bounds and vertices stay close to the target
  task automatic test_random_cells(int count);
    logic signed [VW-1:0] t, lv, rv, la, ra;
    int span;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_cell(rand_value(), rand_value(), rand_value(), rand_value(), rand_value());
      end else begin
        span = 1 << $urandom_range(0, 20);
        t = $urandom_range(0, 1 << 24) - (1 << 23);
        lv = t + $signed($urandom_range(0, 2*span)) - span;
        rv = t + $signed($urandom_range(0, 2*span)) - span;
        la = t + $signed($urandom_range(0, 2*span)) - span;
        ra = t + $signed($urandom_range(0, 2*span)) - span;
        send_cell(lv, rv, la, t, ra);
      end
      if (i % 400 == 200) drain();
      if ($urandom_range(0, 2) == 0) idle_gap();
      if (i % 300 == 150) write_alpha(bjl_pkg::SCALE_WIDTH'($urandom_range(0, 65536)));
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // check every output beat against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_factors.size() == 0) begin
        $error("unexpected beat: limiter_factor %0d", out_limiter_factor);
        error_count++;
      end else begin
        if (out_limiter_factor !== expected_factors[0]) begin
          $error("limiter_factor: expected %0d, actual %0d",
                 expected_factors[0], out_limiter_factor);
          error_count++;
        end
        void'(expected_factors.pop_front());
      end
    end
  end

  initial begin
    alpha_model = bjl_pkg::ONE_Q16;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_alpha_settings();
    test_random_cells(1200);
    drain();
    if (error_count == 0 && expected_factors.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/bjl_pkg.sv
rtl/core/bjl_divider.sv
rtl/core/barth_jespersen_limiter.sv
verif/testbench.sv
